[rtl/mppc_pkg.sv]
package mppc_pkg;

	localparam logic ALU_MUL = 1'b0;
	localparam logic ALU_DIV = 1'b1;

	localparam int unsigned STALL_DUTY = 9830;

	localparam int unsigned MUL_STEPS = 34;
	localparam int unsigned DIV_STEPS = 17;

	typedef struct packed {
		logic               mode;
		logic signed [31:0] target;
		logic signed [15:0] direct_duty;
		logic signed [23:0] measured_speed;
		logic signed [31:0] measured_position;
		logic        [31:0] now_ms;
	} in_item_t;

	typedef struct packed {
		logic signed [15:0] drive;
		logic               stalled;
		logic               stall_event;
		logic               reached;
		logic               reach_event;
	} out_item_t;

	typedef struct packed {
		logic signed [31:0] gain_p;
		logic signed [31:0] gain_i;
		logic signed [31:0] gain_d;
		logic        [22:0] speed_limit;
		logic signed [31:0] position_low;
		logic signed [31:0] position_high;
		logic        [31:0] reach_tolerance;
		logic        [31:0] stall_time_ms;
	} cfg_t;

	typedef struct packed {
		logic        start;
		logic        op;
		logic [31:0] a;
		logic [33:0] b;
	} alu_req_t;

	typedef struct packed {
		logic        done;
		logic [40:0] res;
	} alu_rsp_t;

endpackage

[rtl/mppc_alu.sv]
module mppc_alu (
	input  logic              clk,
	input  logic              arst_n,
	input  mppc_pkg::alu_req_t req,
	output mppc_pkg::alu_rsp_t rsp
);
	import mppc_pkg::*;

	logic        busy_q;
	logic        op_q;
	logic [31:0] a_q;
	logic [33:0] b_q;
	logic [5:0]  cnt_q;
	logic [40:0] acc_q;
	logic        sat_q;
	logic [32:0] rem_q;
	logic        done_q;

	logic [42:0] mul_nxt;
	logic [32:0] div_r;
	logic        div_ge;

	assign mul_nxt = {1'b0, acc_q, 1'b0} + (b_q[33] ? {11'b0, a_q} : 43'd0);
	assign div_r   = {rem_q[31:0], b_q[33]};
	assign div_ge  = div_r >= {1'b0, a_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start && !busy_q) begin
				busy_q <= 1'b1;
			end else if (busy_q && cnt_q == 6'd1) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start && !busy_q) begin
			op_q  <= req.op;
			a_q   <= req.a;
			b_q   <= req.b;
			cnt_q <= (req.op == ALU_MUL) ? 6'(MUL_STEPS) : 6'(DIV_STEPS);
			acc_q <= '0;
			sat_q <= 1'b0;
			rem_q <= '0;
		end else if (busy_q) begin
			b_q   <= {b_q[32:0], 1'b0};
			cnt_q <= cnt_q - 6'd1;
			if (op_q == ALU_MUL) begin
				if (sat_q || mul_nxt > 43'(64'd1 << 40))
					sat_q <= 1'b1;
				acc_q <= mul_nxt[40:0];
			end else begin
				rem_q <= div_ge ? (div_r - {1'b0, a_q}) : div_r;
				acc_q <= {acc_q[39:0], div_ge};
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.res  = sat_q ? 41'(64'd1 << 40) : acc_q;

endmodule

[rtl/mppc_ctrl.sv]
module mppc_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  mppc_pkg::cfg_t      cfg,
	input  logic                in_valid,
	output logic                in_stall,
	input  mppc_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output mppc_pkg::out_item_t out_data,
	output mppc_pkg::alu_req_t  req,
	input  mppc_pkg::alu_rsp_t  rsp
);
	import mppc_pkg::*;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_ERR   = 4'd1;
	localparam logic [3:0] S_DV_GO = 4'd2;
	localparam logic [3:0] S_DV_W  = 4'd3;
	localparam logic [3:0] S_MP_GO = 4'd4;
	localparam logic [3:0] S_MP_W  = 4'd5;
	localparam logic [3:0] S_MI_GO = 4'd6;
	localparam logic [3:0] S_MI_W  = 4'd7;
	localparam logic [3:0] S_MD_GO = 4'd8;
	localparam logic [3:0] S_MD_W  = 4'd9;
	localparam logic [3:0] S_SAT   = 4'd10;
	localparam logic [3:0] S_OUT   = 4'd11;

	logic [3:0]         state_q;
	in_item_t           in_q;
	logic signed [32:0] e_q;
	logic signed [31:0] es_q;
	logic signed [32:0] le_q;
	logic signed [15:0] ld_q;
	logic signed [42:0] u_q;
	logic signed [16:0] qd_q;
	logic               st_timing_q;
	logic [31:0]        st_start_q;
	logic               st_rep_q;
	logic               rc_rep_q;
	logic               rc_flag_q;
	logic               out_valid_q;
	out_item_t          out_q;

	logic signed [31:0] lo, hi, tc;
	logic signed [32:0] e_c;
	logic signed [33:0] d_c;
	logic [33:0]        e_abs, d_abs, es_abs;
	logic               gi_nz, gd_nz;
	logic signed [33:0] es_sum, bnd, es_cl;
	logic               term_neg;
	logic signed [42:0] term;
	logic signed [42:0] u_cl;
	logic [18:0]        w;
	logic signed [17:0] q18;
	logic [23:0]        sp_abs;
	logic signed [17:0] u18, ld18, diff, rl;
	logic signed [15:0] drv;
	logic [16:0]        drv_abs;
	logic               out_free;
	logic               st_cond, st_over;
	logic               rc_in;
	logic               n_timing, n_rep, n_rc_rep, n_rc_flag, st_ev, rc_ev;
	logic [31:0]        n_start;

	assign gi_nz    = cfg.gain_i != 32'sd0;
	assign gd_nz    = cfg.gain_d != 32'sd0;
	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = state_q != S_IDLE;

	always_comb begin
		lo = (cfg.position_low < cfg.position_high) ? cfg.position_low : cfg.position_high;
		hi = (cfg.position_low < cfg.position_high) ? cfg.position_high : cfg.position_low;
		tc = (in_q.target < lo) ? lo : ((in_q.target > hi) ? hi : in_q.target);
		e_c = {tc[31], tc} - {in_q.measured_position[31], in_q.measured_position};
		d_c = {e_q[32], e_q} - {le_q[32], le_q};
		e_abs  = e_q[32] ? -{e_q[32], e_q} : {e_q[32], e_q};
		d_abs  = d_c[33] ? -d_c : d_c;
		es_abs = es_q[31] ? -{{2{es_q[31]}}, es_q} : {{2{es_q[31]}}, es_q};
		es_sum = {{2{es_q[31]}}, es_q} + {e_q[32], e_q};
		bnd    = {17'b0, rsp.res[16:0]};
		es_cl  = (es_sum > bnd) ? bnd : ((es_sum < -bnd) ? -bnd : es_sum);
	end

	always_comb begin
		req.start = 1'b0;
		req.op    = ALU_MUL;
		req.a     = cfg.gain_p[31] ? 32'(-cfg.gain_p) : cfg.gain_p;
		req.b     = e_abs;
		term_neg  = cfg.gain_p[31] ^ e_q[32];
		case (state_q)
			S_DV_GO, S_DV_W: begin
				req.start = state_q == S_DV_GO;
				req.op    = ALU_DIV;
				req.a     = cfg.gain_i[31] ? 32'(-cfg.gain_i) : cfg.gain_i;
				req.b     = 34'(64'd65536 << 17);
			end
			S_MP_GO: begin
				req.start = 1'b1;
			end
			S_MI_GO, S_MI_W: begin
				req.start = state_q == S_MI_GO;
				req.a     = cfg.gain_i[31] ? 32'(-cfg.gain_i) : cfg.gain_i;
				req.b     = es_abs;
				term_neg  = cfg.gain_i[31] ^ es_q[31];
			end
			S_MD_GO, S_MD_W: begin
				req.start = state_q == S_MD_GO;
				req.a     = cfg.gain_d[31] ? 32'(-cfg.gain_d) : cfg.gain_d;
				req.b     = d_abs;
				term_neg  = cfg.gain_d[31] ^ d_c[33];
			end
			default: begin
			end
		endcase
		term = term_neg ? -{2'b0, rsp.res} : {2'b0, rsp.res};
	end

	always_comb begin
		u_cl = (u_q > 43'sd65536) ? 43'sd65536 : ((u_q < -43'sd65536) ? -43'sd65536 : u_q);
		w    = 19'(u_cl + 43'sd65537);
		q18  = 18'({1'b0, w[18:1]}) - 18'sd32768;
		if (q18 > 18'sd32767)
			q18 = 18'sd32767;
		sp_abs = in_q.measured_speed[23] ? 24'(-in_q.measured_speed) : in_q.measured_speed;
		if (sp_abs > {1'b0, cfg.speed_limit})
			q18 = '0;
	end

	always_comb begin
		u18  = {qd_q[16], qd_q};
		ld18 = {{2{ld_q[15]}}, ld_q};
		diff = u18 - ld18;
		rl   = u18;
		if (u18 >= 18'sd29491 && diff > 18'sd3277)
			rl = (ld18 < 18'sd16384) ? 18'sd16384 : ld18 + 18'sd3277;
		else if (u18 <= -18'sd29491 && diff < -18'sd3277)
			rl = (ld18 > -18'sd16384) ? -18'sd16384 : ld18 - 18'sd3277;
		drv     = in_q.mode ? rl[15:0] : qd_q[15:0];
		drv_abs = drv[15] ? -{drv[15], drv} : {drv[15], drv};

		rc_in     = (e_q[32] ? -{e_q[32], e_q} : {e_q[32], e_q}) < {1'b0, cfg.reach_tolerance};
		n_rc_rep  = rc_rep_q;
		n_rc_flag = rc_flag_q;
		rc_ev     = 1'b0;
		if (in_q.mode) begin
			n_rc_flag = rc_in;
			n_rc_rep  = rc_in;
			rc_ev     = rc_in && !rc_rep_q;
		end

		st_cond  = in_q.measured_speed == 24'sd0 && drv_abs > 17'(STALL_DUTY);
		st_over  = (in_q.now_ms - st_start_q) > cfg.stall_time_ms;
		n_timing = st_timing_q;
		n_start  = st_start_q;
		n_rep    = st_rep_q;
		st_ev    = 1'b0;
		if (!st_cond) begin
			n_timing = 1'b0;
			n_start  = '0;
			n_rep    = 1'b0;
		end else if (!st_timing_q) begin
			n_timing = 1'b1;
			n_start  = in_q.now_ms;
		end else if (st_over) begin
			st_ev = !st_rep_q;
			n_rep = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			es_q        <= '0;
			le_q        <= '0;
			ld_q        <= '0;
			st_timing_q <= 1'b0;
			st_start_q  <= '0;
			st_rep_q    <= 1'b0;
			rc_rep_q    <= 1'b0;
			rc_flag_q   <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall && state_q != S_OUT)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_valid)
						state_q <= in_data.mode ? S_ERR : S_OUT;
				end
				S_ERR: state_q <= gi_nz ? S_DV_GO : S_MP_GO;
				S_DV_GO: state_q <= S_DV_W;
				S_DV_W: begin
					if (rsp.done) begin
						es_q    <= es_cl[31:0];
						state_q <= S_MP_GO;
					end
				end
				S_MP_GO: state_q <= S_MP_W;
				S_MP_W: begin
					if (rsp.done)
						state_q <= gi_nz ? S_MI_GO : (gd_nz ? S_MD_GO : S_SAT);
				end
				S_MI_GO: state_q <= S_MI_W;
				S_MI_W: begin
					if (rsp.done)
						state_q <= gd_nz ? S_MD_GO : S_SAT;
				end
				S_MD_GO: state_q <= S_MD_W;
				S_MD_W: begin
					if (rsp.done) begin
						le_q    <= e_q;
						state_q <= S_SAT;
					end
				end
				S_SAT: state_q <= S_OUT;
				S_OUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						if (in_q.mode)
							ld_q <= drv;
						st_timing_q <= n_timing;
						st_start_q  <= n_start;
						st_rep_q    <= n_rep;
						rc_rep_q    <= n_rc_rep;
						rc_flag_q   <= n_rc_flag;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			in_q <= in_data;
			qd_q <= {in_data.direct_duty[15], in_data.direct_duty};
		end
		if (state_q == S_ERR) begin
			e_q <= e_c;
			u_q <= '0;
		end
		if ((state_q == S_MP_W || state_q == S_MI_W || state_q == S_MD_W) && rsp.done)
			u_q <= u_q + term;
		if (state_q == S_SAT)
			qd_q <= q18[16:0];
		if (state_q == S_OUT && out_free) begin
			out_q.drive       <= drv;
			out_q.stalled     <= n_rep;
			out_q.stall_event <= st_ev;
			out_q.reached     <= n_rc_flag;
			out_q.reach_event <= rc_ev;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

[rtl/motor_position_pid_controller_top.sv]
// channel | direction | handshake           | payload
// in      | input     | in_valid / in_stall | in_data   (in_item_t)
// out     | output    | out_valid/out_stall | out_data  (out_item_t)
// cfg     | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// One item at a time. Direct mode goes straight to the output; position mode runs
// the proportional multiply, plus the bound divide and integral multiply when gain_i
// is nonzero and the derivative multiply when gain_d is nonzero, on the bit-serial unit.
// in_stall is high from acceptance until the result moves to the output register;
// a stalled output holds the next result in the sequencer. Reset clears the
// control state and loads the register defaults; no clearing pass.
module motor_position_pid_controller_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  mppc_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output mppc_pkg::out_item_t out_data,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [3:0]          cfg_index,
	input  logic [31:0]         cfg_data
);
	import mppc_pkg::*;

	localparam logic [3:0] REG_GAIN_P   = 4'd0;
	localparam logic [3:0] REG_GAIN_I   = 4'd1;
	localparam logic [3:0] REG_GAIN_D   = 4'd2;
	localparam logic [3:0] REG_SPD_LIM  = 4'd3;
	localparam logic [3:0] REG_POS_LO   = 4'd4;
	localparam logic [3:0] REG_POS_HI   = 4'd5;
	localparam logic [3:0] REG_REACH    = 4'd6;
	localparam logic [3:0] REG_STALL_MS = 4'd7;

	cfg_t     cfg_q;
	alu_req_t req;
	alu_rsp_t rsp;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain_p          <= '0;
			cfg_q.gain_i          <= '0;
			cfg_q.gain_d          <= '0;
			cfg_q.speed_limit     <= '1;
			cfg_q.position_low    <= 32'sh8000_0000;
			cfg_q.position_high   <= 32'sh7FFF_FFFF;
			cfg_q.reach_tolerance <= '0;
			cfg_q.stall_time_ms   <= 32'd500;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_GAIN_P:   cfg_q.gain_p          <= cfg_data;
				REG_GAIN_I:   cfg_q.gain_i          <= cfg_data;
				REG_GAIN_D:   cfg_q.gain_d          <= cfg_data;
				REG_SPD_LIM:  cfg_q.speed_limit     <= cfg_data[22:0];
				REG_POS_LO:   cfg_q.position_low    <= cfg_data;
				REG_POS_HI:   cfg_q.position_high   <= cfg_data;
				REG_REACH:    cfg_q.reach_tolerance <= cfg_data;
				REG_STALL_MS: cfg_q.stall_time_ms   <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	mppc_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	mppc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.req       (req),
		.rsp       (rsp)
	);

endmodule

[dv/tb.sv]
`timescale 1ns / 100ps

module tb;
	import mppc_pkg::*;

	localparam int N_CFG = 8;
	localparam int IDX_GAIN_P = 0;
	localparam int IDX_GAIN_I = 1;
	localparam int IDX_GAIN_D = 2;
	localparam int IDX_SPEED_LIMIT = 3;
	localparam int IDX_POS_LOW = 4;
	localparam int IDX_POS_HIGH = 5;
	localparam int IDX_REACH_TOL = 6;
	localparam int IDX_STALL_TIME = 7;
	localparam longint TERM_CAP = 64'sd1 << 40;
	localparam longint ONE_Q16 = 65536;
	localparam longint RATE_ON = 29491;
	localparam longint RATE_STEP = 3277;
	localparam longint RATE_HALF = 16384;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_item_t out_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [3:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int mismatches = 0;
	out_item_t drive_queue[$];

	// predictor state
	logic [31:0] regs[N_CFG];
	longint pid_sum, pid_last_err, prev_drive;
	logic [31:0] stall_t0;
	bit stall_run, stall_seen, reach_seen, reach_lvl;

	motor_position_pid_controller_top dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #4 clk = ~clk;

	initial begin
		#50ms;
		$display("tb NOT OK");
		$finish;
	end

	function automatic longint sat_mul(longint a, longint b);
		longint unsigned ma, mb, p;
		bit neg;
		neg = (a < 0) != (b < 0);
		ma = (a < 0) ? -a : a;
		mb = (b < 0) ? -b : b;
		p = ma * mb;
		if (p > TERM_CAP) p = TERM_CAP;
		return neg ? -longint'(p) : longint'(p);
	endfunction

	function automatic longint clip(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic out_item_t control_tick(in_item_t it);
		out_item_t r;
		longint tgt, e, u, bnd, gp, gi, gd, lo, hi, pl, ph, spd, drv, mag;
		bit sev, rev;
		sev = 0;
		rev = 0;
		gp = longint'($signed(regs[IDX_GAIN_P]));
		gi = longint'($signed(regs[IDX_GAIN_I]));
		gd = longint'($signed(regs[IDX_GAIN_D]));
		pl = longint'($signed(regs[IDX_POS_LOW]));
		ph = longint'($signed(regs[IDX_POS_HIGH]));
		spd = longint'(it.measured_speed);
		if (!it.mode) begin
			drv = longint'(it.direct_duty);
		end else begin
			lo = pl < ph ? pl : ph;
			hi = pl < ph ? ph : pl;
			tgt = clip(longint'(it.target), lo, hi);
			e = tgt - longint'(it.measured_position);
			u = sat_mul(gp, e);
			if (gi != 0) begin
				bnd = ONE_Q16 / (gi < 0 ? -gi : gi);
				pid_sum = clip(pid_sum + e, -bnd, bnd);
				u += sat_mul(gi, pid_sum);
			end
			if (gd != 0) begin
				u += sat_mul(gd, e - pid_last_err);
				pid_last_err = e;
			end
			u = clip(u, -ONE_Q16, ONE_Q16);
			u = ((u + ONE_Q16 + 1) >>> 1) - 32768;
			if (u > 32767) u = 32767;
			if (spd > longint'(regs[IDX_SPEED_LIMIT]) || spd < -longint'(regs[IDX_SPEED_LIMIT]))
				u = 0;
			if (u >= RATE_ON && u - prev_drive > RATE_STEP)
				u = prev_drive < RATE_HALF ? RATE_HALF : prev_drive + RATE_STEP;
			else if (u <= -RATE_ON && u - prev_drive < -RATE_STEP)
				u = prev_drive > -RATE_HALF ? -RATE_HALF : prev_drive - RATE_STEP;
			drv = u;
			prev_drive = u;
			mag = e < 0 ? -e : e;
			if (mag < longint'(regs[IDX_REACH_TOL])) begin
				if (!reach_seen) begin
					rev = 1;
					reach_seen = 1;
				end
				reach_lvl = 1;
			end else begin
				reach_lvl = 0;
				reach_seen = 0;
			end
		end
		if (spd == 0 && (drv < 0 ? -drv : drv) > STALL_DUTY) begin
			if (!stall_run) begin
				stall_run = 1;
				stall_t0 = it.now_ms;
			end else if (32'(it.now_ms - stall_t0) > regs[IDX_STALL_TIME]) begin
				if (!stall_seen) sev = 1;
				stall_seen = 1;
			end
		end else begin
			stall_run = 0;
			stall_t0 = '0;
			stall_seen = 0;
		end
		r.drive = drv[15:0];
		r.stalled = stall_seen;
		r.stall_event = sev;
		r.reached = reach_lvl;
		r.reach_event = rev;
		return r;
	endfunction

	always @(posedge clk) begin
		if (out_valid && !out_stall) begin
			if (drive_queue.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected transfer %p", out_data);
			end else begin
				out_item_t x;
				x = drive_queue.pop_front();
				if (x !== out_data) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %p actual %p", x, out_data);
				end
			end
		end
		out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	task automatic send_tick(in_item_t it);
		while ($urandom_range(99) < send_idle_pct) @(posedge clk);
		in_valid <= 1'b1;
		in_data <= it;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		drive_queue.push_back(control_tick(it));
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (drive_queue.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	task automatic write_reg(int idx, logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx[3:0];
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		regs[idx] = idx == IDX_SPEED_LIMIT ? {9'b0, val[22:0]} : val;
		@(posedge clk);
	endtask

	function automatic in_item_t rand_tick(bit pos);
		in_item_t it;
		it.mode = pos;
		it.direct_duty = 16'($urandom);
		it.now_ms = $urandom;
		case ($urandom_range(3))
			0: it.target = $urandom;
			default: it.target = $signed($urandom_range(4000)) - 2000;
		endcase
		it.measured_position = ($urandom_range(3) == 0) ? $urandom :
			$signed($urandom_range(4000)) - 2000;
		case ($urandom_range(3))
			0: it.measured_speed = 24'($urandom);
			1: it.measured_speed = '0;
			default: it.measured_speed = 24'($signed($urandom_range(200)) - 100);
		endcase
		return it;
	endfunction

	task automatic test_directed();
		in_item_t it;
		int k;
		it = '0;
		it.mode = 1'b0;
		it.direct_duty = 16'sh7fff; send_tick(it);
		it.direct_duty = 16'sh8000; send_tick(it);
		it.now_ms = 32'd1000; send_tick(it);
		it.now_ms = 32'd1600; send_tick(it);
		it.now_ms = 32'd1700; send_tick(it);
		it.measured_speed = 24'sh7fffff; send_tick(it);
		it.measured_speed = 24'sh800000; send_tick(it);
		drain();
		write_reg(IDX_GAIN_P, 32'h0001_0000);
		write_reg(IDX_REACH_TOL, 32'd5);
		it.mode = 1'b1;
		it.measured_speed = '0;
		it.target = 32'sh7fffffff; it.measured_position = 32'sh80000000; send_tick(it);
		send_tick(it); send_tick(it);
		it.target = 32'sh80000000; it.measured_position = 32'sh7fffffff; send_tick(it);
		send_tick(it);
		it.target = 100; it.measured_position = 98; send_tick(it);
		send_tick(it);
		it.measured_position = 200; send_tick(it);
		for (k = 0; k < 4; k++) begin
			it.target = 32'sh40000000; it.measured_position = 0;
			it.now_ms = 32'hffff_fff0 + k * 400;
			send_tick(it);
		end
		drain();
	endtask

	task automatic apply_setting(int s);
		case (s)
			0: begin
				write_reg(IDX_GAIN_P, 32'h0000_4000); write_reg(IDX_GAIN_I, 32'h0000_0100);
				write_reg(IDX_GAIN_D, 32'h0000_8000); write_reg(IDX_SPEED_LIMIT, 32'd50);
				write_reg(IDX_POS_LOW, 32'd1500); write_reg(IDX_POS_HIGH, -32'sd1500);
				write_reg(IDX_REACH_TOL, 32'd40); write_reg(IDX_STALL_TIME, 32'd3);
			end
			1: begin
				write_reg(IDX_GAIN_P, 32'h7fff_ffff); write_reg(IDX_GAIN_I, 32'h8000_0000);
				write_reg(IDX_GAIN_D, 32'h8000_0000); write_reg(IDX_SPEED_LIMIT, 32'h7f_ffff);
				write_reg(IDX_POS_LOW, 32'h8000_0000); write_reg(IDX_POS_HIGH, 32'h7fff_ffff);
				write_reg(IDX_REACH_TOL, 32'hffff_ffff); write_reg(IDX_STALL_TIME, 32'd0);
			end
			2: begin
				write_reg(IDX_GAIN_P, 32'h8000_0000); write_reg(IDX_GAIN_I, 32'h7fff_ffff);
				write_reg(IDX_GAIN_D, 32'h7fff_ffff); write_reg(IDX_SPEED_LIMIT, 32'd0);
				write_reg(IDX_REACH_TOL, 32'd0); write_reg(IDX_STALL_TIME, 32'hffff_ffff);
			end
			default: begin
				write_reg(IDX_GAIN_P, $urandom); write_reg(IDX_GAIN_I, 32'($signed($urandom_range(2000)) - 1000));
				write_reg(IDX_GAIN_D, $urandom_range(1) ? $urandom : 32'd0);
				write_reg(IDX_SPEED_LIMIT, $urandom_range(120));
				write_reg(IDX_POS_LOW, $signed($urandom_range(4000)) - 2000);
				write_reg(IDX_POS_HIGH, $signed($urandom_range(4000)) - 2000);
				write_reg(IDX_REACH_TOL, $urandom_range(300));
				write_reg(IDX_STALL_TIME, $urandom_range(20));
			end
		endcase
	endtask

	task automatic test_random(int s, int n, int idle, int stall);
		in_item_t it;
		logic [31:0] clock_ms;
		int k;
		apply_setting(s);
		send_idle_pct = idle;
		recv_stall_pct = stall;
		clock_ms = $urandom;
		for (k = 0; k < n; k++) begin
			it = rand_tick($urandom_range(9) != 0);
			// advance time monotonically most of the time so stalls can mature
			if ($urandom_range(9) != 0) begin
				clock_ms += $urandom_range(3);
				it.now_ms = clock_ms;
			end
			if (k == n / 2) drain();
			send_tick(it);
		end
		drain();
	endtask

	initial begin
		regs[IDX_GAIN_P] = 0; regs[IDX_GAIN_I] = 0; regs[IDX_GAIN_D] = 0;
		regs[IDX_SPEED_LIMIT] = 32'h7f_ffff; regs[IDX_POS_LOW] = 32'h8000_0000;
		regs[IDX_POS_HIGH] = 32'h7fff_ffff; regs[IDX_REACH_TOL] = 0;
		regs[IDX_STALL_TIME] = 500;
		pid_sum = 0; pid_last_err = 0; prev_drive = 0;
		stall_t0 = 0; stall_run = 0; stall_seen = 0; reach_seen = 0; reach_lvl = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(0, 250, 0, 0);
		test_random(1, 200, 58, 0);
		test_random(2, 200, 0, 58);
		test_random(3, 300, 37, 37);
		test_random(4, 300, 0, 0);
		test_random(5, 250, 58, 58);
		test_random(3, 250, 37, 37);
		if (mismatches == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end
endmodule
